@@ src/rrts_pkg.sv @@
// Shared types and constants for the round-robin time-slice scheduler.
// Depends on nothing; rrts_fifo and the scheduler top in src refer to it by scoped names.
package rrts_pkg;

  // Default sizing handed to the top-level parameters
  localparam int MaxProcsDef  = 16;
  localparam int TimeBitsDef  = 32;
  localparam logic [7:0] QuantumRst = 8'd4;

  // Input command codes
  typedef enum logic {
    CMD_ARRIVAL = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_t;

  // Input transaction payload
  typedef struct packed {
    cmd_t        cmd;
    logic [3:0]  slot;
    logic [15:0] burst;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic [31:0] now_time;
    logic [3:0]  run_slot;
    logic        is_idle;
    logic        finished;
    logic [31:0] done_time;
    logic [31:0] turnaround;
    logic [31:0] waiting;
  } out_item_t;

  // Configuration write payload
  typedef struct packed {
    logic [7:0] quantum;
  } cfg_item_t;

  // Ready-queue control and status between the top level and the queue
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_sts_t;

  // Low 32 bits of a time value that was zero-extended to 64 bits
  function automatic logic [31:0] low32(logic [63:0] v);
    return v[31:0];
  endfunction

endpackage

@@ src/rrts_chan_if.sv @@
// Valid/ready channel carrying one payload type per transaction.
// Depends on nothing; the payload type comes in as a type parameter.
interface rrts_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/rrts_fifo.sv @@
// Ready queue of process entries: one write port, one registered read of the head.
// Depends on rrts_pkg for the control and status structs.
module rrts_fifo #(
  parameter int DEPTH  = rrts_pkg::MaxProcsDef,
  parameter int DATA_W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rrts_pkg::fifo_ctl_t   ctl,
  input  logic [DATA_W-1:0]     wr_data,
  output rrts_pkg::fifo_sts_t   sts,
  output logic [DATA_W-1:0]     head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DATA_W-1:0] head_data_r;
  logic [SUM_W-1:0]  tail_sum;
  logic [PTR_W-1:0]  tail;
  logic              wr_en;

  // Status flags
  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CNT_W'(DEPTH));

  // Tail position, wrapped at the depth
  assign tail_sum = {1'b0, head_r} + SUM_W'(count_r);
  assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                               : PTR_W'(tail_sum);

  // Drop a push into a full queue unless a pop frees a place
  assign wr_en = ctl.push && (!sts.full || ctl.pop);

  // Advance head and count
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ctl.pop) begin
      head_nxt = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (wr_en && !ctl.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= wr_data;
    end
  end

  // Registered head read, forwarding a write that lands on the new head
  always_ff @(posedge clk) begin
    if (wr_en && (tail == head_nxt)) begin
      head_data_r <= wr_data;
    end else begin
      head_data_r <= mem[head_nxt];
    end
  end

  assign head_data = head_data_r;

endmodule

@@ src/round_robin_time_slice_scheduler_unit.sv @@
// Round-robin time-slice scheduler: arrivals queue process slots, ticks run them.
// Depends on rrts_pkg, rrts_chan_if and rrts_fifo.
//
//   channel | dir | payload            | transaction
//   --------+-----+--------------------+-----------------------------------------
//   in_if   | in  | cmd, slot, burst   | arrival (no result) or tick (one result)
//   out_if  | out | tick report fields | one per tick
//   cfg_if  | in  | quantum            | quantum write, always ready
//
// One transaction per cycle in both directions while the result side does not
// stall. An accepted transaction is held in the input register; the scheduling
// step then runs combinationally from it into the result register, from which
// a tick report is offered. Synchronous reset empties the queue and clears
// all slot-busy flags at once. A stalled result holds a tick in the input
// register and everything behind it; arrivals that reach the input register
// ahead of that tick go through without waiting.
module round_robin_time_slice_scheduler_unit #(
  parameter int MAX_PROCS = rrts_pkg::MaxProcsDef,
  parameter int TIME_BITS = rrts_pkg::TimeBitsDef
) (
  input logic clk,
  input logic rst_n,
  rrts_chan_if.sink   in_if,
  rrts_chan_if.source out_if,
  rrts_chan_if.sink   cfg_if
);

  localparam int TB    = TIME_BITS;
  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int ENT_W = 4 + 16 + TB + TB + 1;

  // Configuration
  logic [7:0] quantum_r;

  // Input and result registers
  rrts_pkg::in_item_t  in_data_r;
  logic                in_valid_r;
  rrts_pkg::out_item_t out_data_r, out_data_nxt;
  logic                out_valid_r;
  logic                fire;
  logic                fire_tick;

  // Scheduler state
  logic [MAX_PROCS-1:0] busy_r, busy_nxt;
  logic [TB-1:0]        time_r, time_inc;
  logic                 cur_valid_r, cur_valid_nxt;
  logic                 pend_r, pend_nxt;
  logic [3:0]           cur_slot_r, cur_slot_nxt;
  logic [15:0]          cur_rem_r, cur_rem_nxt;
  logic [TB-1:0]        cur_arr_r, cur_arr_nxt;
  logic [TB:0]          cur_ab_r, cur_ab_nxt;
  logic [7:0]           slice_r, slice_nxt;

  // Queue interface
  rrts_pkg::fifo_ctl_t  fifo_ctl;
  rrts_pkg::fifo_sts_t  fifo_sts;
  logic [ENT_W-1:0]     fifo_wdata;
  logic [ENT_W-1:0]     head_ent;

  // Decoded step signals
  logic             arr_ok;
  logic [IDX_W-1:0] arr_idx;
  logic             use_cur;
  logic             run_valid;
  logic [3:0]       run_slot;
  logic [15:0]      run_rem;
  logic [TB-1:0]    run_arr;
  logic [TB:0]      run_ab;
  logic [7:0]       slice_new;
  logic [15:0]      rem_new;
  logic             run_done;
  logic [TB-1:0]    ta;
  logic [TB:0]      wt;

  // Configuration port
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= rrts_pkg::QuantumRst;
    end else if (cfg_if.valid) begin
      quantum_r <= cfg_if.data.quantum;
    end
  end

  // Handshakes: arrivals need no result space
  assign fire = in_valid_r && ((in_data_r.cmd == rrts_pkg::CMD_ARRIVAL) ||
                               !out_valid_r || out_if.ready);
  assign fire_tick   = fire && (in_data_r.cmd == rrts_pkg::CMD_TICK);
  assign in_if.ready = !in_valid_r || fire;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_data_r <= in_if.data;
    end
  end

  // Arrival admission
  assign arr_idx = IDX_W'(in_data_r.slot);
  assign arr_ok  = ({28'd0, in_data_r.slot} < 32'(MAX_PROCS)) &&
                   (in_data_r.burst != '0) && !busy_r[arr_idx];

  // Saturating time advance
  assign time_inc = (&time_r) ? time_r : time_r + 1'b1;

  // Select the slot that runs this tick
  assign use_cur   = cur_valid_r || (pend_r && fifo_sts.empty);
  assign run_valid = cur_valid_r || pend_r || !fifo_sts.empty;
  assign run_slot  = use_cur ? cur_slot_r : head_ent[ENT_W-1 -: 4];
  assign run_rem   = use_cur ? cur_rem_r  : head_ent[ENT_W-5 -: 16];
  assign run_arr   = use_cur ? cur_arr_r  : head_ent[2*TB : TB+1];
  assign run_ab    = use_cur ? cur_ab_r   : head_ent[TB:0];
  assign slice_new = (cur_valid_r ? slice_r : 8'd0) + 8'd1;
  assign rem_new   = run_rem - 16'd1;
  assign run_done  = (run_rem == 16'd1);

  // Completion figures; waiting compares against arrival plus burst
  assign ta = time_inc - run_arr;
  assign wt = ({1'b0, time_inc} >= run_ab) ? {1'b0, time_inc} - run_ab : '0;

  // Queue requests
  always_comb begin
    fifo_ctl   = '0;
    fifo_wdata = {in_data_r.slot, in_data_r.burst, time_r,
                  {1'b0, time_r} + (TB+1)'(in_data_r.burst)};
    if (fire && (in_data_r.cmd == rrts_pkg::CMD_ARRIVAL)) begin
      fifo_ctl.push = arr_ok;
    end else if (fire_tick) begin
      fifo_ctl.push = pend_r && !fifo_sts.empty;
      fifo_ctl.pop  = !cur_valid_r && !fifo_sts.empty;
      fifo_wdata    = {cur_slot_r, cur_rem_r, cur_arr_r, cur_ab_r};
    end
  end

  rrts_fifo #(
    .DEPTH  (MAX_PROCS),
    .DATA_W (ENT_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fifo_ctl),
    .wr_data   (fifo_wdata),
    .sts       (fifo_sts),
    .head_data (head_ent)
  );

  // Scheduling step
  always_comb begin
    busy_nxt      = busy_r;
    cur_valid_nxt = cur_valid_r;
    pend_nxt      = pend_r;
    cur_slot_nxt  = cur_slot_r;
    cur_rem_nxt   = cur_rem_r;
    cur_arr_nxt   = cur_arr_r;
    cur_ab_nxt    = cur_ab_r;
    slice_nxt     = slice_r;
    out_data_nxt  = '0;
    out_data_nxt.now_time = rrts_pkg::low32(64'(time_inc));

    if (fire && (in_data_r.cmd == rrts_pkg::CMD_ARRIVAL) && arr_ok) begin
      busy_nxt[arr_idx] = 1'b1;
    end

    if (fire_tick) begin
      pend_nxt      = 1'b0;
      cur_valid_nxt = 1'b0;
      if (!run_valid) begin
        out_data_nxt.is_idle = 1'b1;
      end else begin
        out_data_nxt.run_slot = run_slot;
        cur_slot_nxt = run_slot;
        cur_rem_nxt  = rem_new;
        cur_arr_nxt  = run_arr;
        cur_ab_nxt   = run_ab;
        slice_nxt    = slice_new;
        if (run_done) begin
          // Retire the slot and report its times
          busy_nxt[IDX_W'(run_slot)] = 1'b0;
          out_data_nxt.finished   = 1'b1;
          out_data_nxt.done_time  = rrts_pkg::low32(64'(time_inc));
          out_data_nxt.turnaround = rrts_pkg::low32(64'(ta));
          out_data_nxt.waiting    = rrts_pkg::low32(64'(wt));
        end else if (slice_new >= quantum_r) begin
          // Hold the preempted slot for requeue on the next tick
          pend_nxt = 1'b1;
        end else begin
          cur_valid_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      time_r      <= '0;
      cur_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      cur_slot_r  <= '0;
      slice_r     <= '0;
    end else begin
      busy_r      <= busy_nxt;
      cur_valid_r <= cur_valid_nxt;
      pend_r      <= pend_nxt;
      cur_slot_r  <= cur_slot_nxt;
      slice_r     <= slice_nxt;
      if (fire_tick) begin
        time_r <= time_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_rem_r <= cur_rem_nxt;
    cur_arr_r <= cur_arr_nxt;
    cur_ab_r  <= cur_ab_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire_tick) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_tick) begin
      out_data_r <= out_data_nxt;
    end
  end

  // A slot is never both running and waiting for requeue
  a_cur_pend_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cur_valid_r && pend_r))
    else $error("running and requeue-pending both set");

  // The held slot, running or preempted, stays marked busy
  a_cur_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r || pend_r) |-> busy_r[IDX_W'(cur_slot_r)])
    else $error("held slot not marked busy");

  // An admitted arrival always finds room in the queue
  a_arr_room: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (in_data_r.cmd == rrts_pkg::CMD_ARRIVAL) && arr_ok) |-> !fifo_sts.full)
    else $error("arrival pushed into a full ready queue");

  // A completed slot reports its done time as the tick time
  a_done_time: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.finished) |->
      (!out_data_r.is_idle && (out_data_r.done_time == out_data_r.now_time)))
    else $error("completion report inconsistent with tick time");

endmodule

@@ dv/rrts_sched_checker.sv @@
// Checker for the round-robin time-slice scheduler: watches the input, result and
// quantum channels, predicts every tick report and compares it field by field.
// Depends on rrts_pkg for the payload types and the reset quantum.
module rrts_sched_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  rrts_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  rrts_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  rrts_pkg::cfg_item_t cfg_data,
  output int unsigned         err_count,
  output int unsigned         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = rrts_pkg::MaxProcsDef;

  // Scheduler image kept alongside the block
  logic [7:0]  quantum;
  logic [3:0]  ready_slots[$];
  logic [15:0] work_left[Slots];
  logic [31:0] stamped_at[Slots];
  logic [15:0] service_len[Slots];
  logic        occupied[Slots];
  logic [31:0] clock_now;
  logic [3:0]  active_slot;
  logic        active;
  logic [7:0]  slice_used;
  logic        requeue_due;
  logic [3:0]  requeue_id;

  // Tick reports predicted but not yet seen on the result channel
  rrts_pkg::out_item_t tick_reports_q[$];

  task automatic enqueue_ready(logic [3:0] s);
    // Drop a push into a full queue
    if (ready_slots.size() < Slots) ready_slots.insert(ready_slots.size(), s);
  endtask

  // Stamp a free slot and queue it; ignore zero bursts and busy slots
  task automatic admit_arrival(rrts_pkg::in_item_t it);
    if (it.burst == '0 || occupied[it.slot]) return;
    stamped_at[it.slot]  = clock_now;
    service_len[it.slot] = it.burst;
    work_left[it.slot]   = it.burst;
    occupied[it.slot]    = 1'b1;
    enqueue_ready(it.slot);
  endtask

  // Advance one time unit and work out the report of this tick
  task automatic predict_tick_report();
    rrts_pkg::out_item_t rpt;
    logic [31:0]         ta;
    rpt = '0;
    if (requeue_due) begin
      enqueue_ready(requeue_id);
      requeue_due = 1'b0;
    end
    if (!active && ready_slots.size() > 0) begin
      active_slot = ready_slots.pop_front();
      active      = 1'b1;
      slice_used  = '0;
    end
    // Saturate time at the top of its range
    if (clock_now != '1) clock_now++;
    rpt.now_time = clock_now;
    if (!active) begin
      rpt.is_idle = 1'b1;
    end else begin
      rpt.run_slot = active_slot;
      work_left[active_slot]--;
      slice_used++;
      if (work_left[active_slot] == '0) begin
        ta = clock_now - stamped_at[active_slot];
        rpt.finished   = 1'b1;
        rpt.done_time  = clock_now;
        rpt.turnaround = ta;
        rpt.waiting    = (ta >= 32'(service_len[active_slot])) ?
                         ta - 32'(service_len[active_slot]) : '0;
        occupied[active_slot] = 1'b0;
        active = 1'b0;
      end else if (slice_used >= quantum) begin
        // Quantum used up: requeue at the start of the next tick
        requeue_due = 1'b1;
        requeue_id  = active_slot;
        active      = 1'b0;
      end
    end
    tick_reports_q.insert(tick_reports_q.size(), rpt);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare one accepted report with the oldest prediction
  task automatic compare_report(rrts_pkg::out_item_t got);
    rrts_pkg::out_item_t want;
    if (tick_reports_q.size() == 0) begin
      err_count++;
      $display("%0t ns: unexpected report, expected none, actual now_time %0d slot %0d",
               $time, got.now_time, got.run_slot);
      return;
    end
    want = tick_reports_q.pop_front();
    check_field("now_time", want.now_time, got.now_time);
    check_field("run_slot", 32'(want.run_slot), 32'(got.run_slot));
    check_field("is_idle", 32'(want.is_idle), 32'(got.is_idle));
    check_field("finished", 32'(want.finished), 32'(got.finished));
    check_field("done_time", want.done_time, got.done_time);
    check_field("turnaround", want.turnaround, got.turnaround);
    check_field("waiting", want.waiting, got.waiting);
  endtask

  // Sample every channel at the rising edge; results first, they stem from older ticks
  always @(posedge clk) begin
    if (!rst_n) begin
      quantum     = rrts_pkg::QuantumRst;
      ready_slots.delete();
      tick_reports_q.delete();
      for (int i = 0; i < Slots; i++) begin
        work_left[i]   = '0;
        stamped_at[i]  = '0;
        service_len[i] = '0;
        occupied[i]    = 1'b0;
      end
      clock_now   = '0;
      active_slot = '0;
      active      = 1'b0;
      slice_used  = '0;
      requeue_due = 1'b0;
      requeue_id  = '0;
      err_count   = 0;
    end else begin
      if (out_valid && out_ready) compare_report(out_data);
      if (cfg_valid && cfg_ready) quantum = cfg_data.quantum;
      if (in_valid && in_ready) begin
        if (in_data.cmd == rrts_pkg::CMD_TICK) predict_tick_report();
        else admit_arrival(in_data);
      end
    end
    pending = tick_reports_q.size();
  end

endmodule

@@ dv/tb_round_robin_time_slice_scheduler_unit.sv @@
// Testbench top for the round-robin time-slice scheduler: clock, reset, stimulus
// through rrts_chan_if channels and the final verdict. Depends on rrts_pkg,
// rrts_chan_if, the scheduler RTL and rrts_sched_checker.
module tb_round_robin_time_slice_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 2000;
  localparam int ItemsPerPhase = 200;
  localparam int Phases        = 6;

  logic        clk;
  logic        rst_n;
  bit          steady;
  int unsigned err_count;
  int unsigned pending;
  int unsigned quiet_cycles;

  rrts_chan_if #(.payload_t(rrts_pkg::in_item_t))  in_if ();
  rrts_chan_if #(.payload_t(rrts_pkg::out_item_t)) out_if ();
  rrts_chan_if #(.payload_t(rrts_pkg::cfg_item_t)) cfg_if ();

  round_robin_time_slice_scheduler_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  rrts_sched_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_data   (in_if.data),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_if.data),
    .cfg_valid (cfg_if.valid),
    .cfg_ready (cfg_if.ready),
    .cfg_data  (cfg_if.data),
    .err_count (err_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the result side at random, about 28 percent of the time, except in the steady phase
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= steady || ($urandom_range(99) >= 28);
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic rrts_pkg::in_item_t make_item(rrts_pkg::cmd_t cmd, logic [3:0] slot,
                                                   logic [15:0] burst);
    rrts_pkg::in_item_t it;
    it.cmd   = cmd;
    it.slot  = slot;
    it.burst = burst;
    return it;
  endfunction

  // Mostly ticks and short bursts so slots finish; a few zero and long bursts
  function automatic rrts_pkg::in_item_t random_item();
    rrts_pkg::in_item_t it;
    int unsigned        pick;
    int unsigned        len_pick;
    pick       = $urandom_range(99);
    len_pick   = $urandom_range(99);
    it.slot    = 4'($urandom_range(15));
    it.burst   = 16'($urandom_range(65535));
    if (pick < 55) begin
      it.cmd = rrts_pkg::CMD_TICK;
    end else begin
      it.cmd = rrts_pkg::CMD_ARRIVAL;
      if (len_pick < 2) begin
        // keep the full-range burst
      end else if (len_pick < 6) begin
        it.burst = '0;
      end else if (len_pick < 12) begin
        it.burst = 16'($urandom_range(13, 300));
      end else begin
        it.burst = 16'($urandom_range(1, 12));
      end
    end
    return it;
  endfunction

  // Offer one transaction at the falling edge and hold it until accepted
  task automatic send_item(rrts_pkg::in_item_t it);
    while (!steady && $urandom_range(99) < 28) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // Wait out every predicted report, then let a trailing arrival settle
  task automatic drain_reports();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_quantum(logic [7:0] q);
    cfg_if.valid        <= 1'b1;
    cfg_if.data.quantum <= q;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] q;

    rst_n        = 1'b0;
    steady       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Idle tick with stray fields, zero burst, occupied slot, long burst, requeue
    send_item(make_item(rrts_pkg::CMD_TICK, 4'hF, 16'hFFFF));
    send_item(make_item(rrts_pkg::CMD_ARRIVAL, 4'h0, 16'h0000));
    send_item(make_item(rrts_pkg::CMD_ARRIVAL, 4'h0, 16'd3));
    send_item(make_item(rrts_pkg::CMD_ARRIVAL, 4'h0, 16'd5));
    send_item(make_item(rrts_pkg::CMD_ARRIVAL, 4'h1, 16'd6));
    send_item(make_item(rrts_pkg::CMD_ARRIVAL, 4'hF, 16'hFFFF));
    repeat (4) send_item(make_item(rrts_pkg::CMD_TICK, 4'h0, 16'h0000));
    send_item(make_item(rrts_pkg::CMD_ARRIVAL, 4'h2, 16'd1));
    repeat (6) send_item(make_item(rrts_pkg::CMD_TICK, 4'h0, 16'h0000));
    send_item(make_item(rrts_pkg::CMD_ARRIVAL, 4'h3, 16'd2));
    repeat (4) send_item(make_item(rrts_pkg::CMD_TICK, 4'h0, 16'h0000));

    // First phase runs at the reset quantum; later ones rewrite it
    for (int p = 0; p < Phases; p++) begin
      if (p > 0) begin
        in_if.valid <= 1'b0;
        drain_reports();
        case (p)
          1:       q = 8'd1;
          2:       q = 8'd255;
          3:       q = 8'd0;
          4:       q = 8'd3;
          default: q = 8'($urandom_range(2, 254));
        endcase
        write_quantum(q);
      end
      steady = (p == 2);
      for (int n = 0; n < ItemsPerPhase; n++) send_item(random_item());
    end
    steady = 1'b0;

    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
